@@ design/fpa_pkg.sv @@
// ----------------------------------------------------------------------------
// Fixed-partition allocator package
// Shared widths, codes and word types for the allocator core and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

  // Default number of partition cells.
  localparam int MAX_BLOCKS_DEF = 64;

  // Field widths fixed by the interface.
  localparam int SIZE_W     = 16;
  localparam int BIDX_W     = 6;
  localparam int BCNT_W     = 7;
  localparam int MODE_W     = 2;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 7;

  // Operation codes of an input word.
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_REQ   = 2'd2;

  // Status codes of a result word.
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ALLOC = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE  = 2'd2;

  // Fit modes. Any other code behaves as first fit.
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] CFG_FIT_MODE    = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_BLOCK_COUNT = 1'b1;

  // Reset value of the block count register.
  localparam logic [BCNT_W-1:0] BLOCK_COUNT_RST = 7'd64;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BIDX_W-1:0] block_index;
    logic [SIZE_W-1:0] size;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BIDX_W-1:0]   granted_block;
  } out_word_t;

  // Search token that walks down the cell row.
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [SIZE_W-1:0] req;
    logic [SIZE_W-1:0] best_size;
  } scan_tok_t;

  // Broadcast controls from the core to every cell.
  typedef struct packed {
    logic              clear;
    logic              wr_en;
    logic [BIDX_W-1:0] wr_idx;
    logic [SIZE_W-1:0] wr_size;
    logic              grant_en;
    logic [MODE_W-1:0] mode;
    logic [BCNT_W-1:0] block_count;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ design/fpa_cell.sv @@
// ----------------------------------------------------------------------------
// Partition cell
// Holds one partition size and its taken flag, and refines the search token
// that passes through it on its way to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_cell
  import fpa_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int CELL_IDX   = 0,
  localparam int IDX_W     = $clog2(MAX_BLOCKS)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cell_ctl_t        ctl,
  input  wire logic [IDX_W-1:0] grant_idx,
  input  wire scan_tok_t        tok_in,
  input  wire logic [IDX_W-1:0] bidx_in,
  output      scan_tok_t        tok_out,
  output      logic [IDX_W-1:0] bidx_out
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [SIZE_W-1:0] size_r;
  logic              taken_r;
  scan_tok_t         tok_r;
  scan_tok_t         tok_nxt;
  logic [IDX_W-1:0]  bidx_r;
  logic [IDX_W-1:0]  bidx_nxt;
  logic              in_use;
  logic              fits;
  logic              better;
  logic              take;

  // Decide whether this partition replaces the candidate carried so far.
  always_comb begin
    in_use   = CELL_IDX < int'(ctl.block_count);
    fits     = in_use && !taken_r && (size_r >= tok_in.req);
    better   = !tok_in.found ||
               ((ctl.mode == MODE_BEST)  && (size_r < tok_in.best_size)) ||
               ((ctl.mode == MODE_WORST) && (size_r > tok_in.best_size));
    take     = tok_in.valid && fits && better;
    tok_nxt  = tok_in;
    bidx_nxt = bidx_in;
    if (take) begin
      tok_nxt.found     = 1'b1;
      tok_nxt.best_size = size_r;
      bidx_nxt          = MY_IDX;
    end
  end

  // Token valid and taken flag are control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
      taken_r     <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
      if (ctl.clear) begin
        taken_r <= 1'b0;
      end else if (ctl.grant_en && (grant_idx == MY_IDX)) begin
        taken_r <= 1'b1;
      end
    end
  end

  // Token payload and partition size need no reset.
  always_ff @(posedge clk) begin
    tok_r.found     <= tok_nxt.found;
    tok_r.req       <= tok_nxt.req;
    tok_r.best_size <= tok_nxt.best_size;
    bidx_r          <= bidx_nxt;
    if (ctl.wr_en && (int'(ctl.wr_idx) == CELL_IDX)) begin
      size_r <= ctl.wr_size;
    end
  end

  assign tok_out  = tok_r;
  assign bidx_out = bidx_r;

endmodule

`default_nettype wire

@@ design/fixed_partition_allocator_core.sv @@
// ----------------------------------------------------------------------------
// Fixed-partition allocator core
// Load, clear and allocation requests over a row of partition cells, with
// first-fit, best-fit and worst-fit selection.
// ----------------------------------------------------------------------------
// Flow: a word is taken only in the idle state. A request first walks the search
//   token down the row, one cell per cycle; for every word the done state then
//   registers the result word once the output register is free. One word at a
//   time: the core takes no new word until that result word is registered.
// Reset: synchronous, active low; all partitions free, fit mode first fit,
//   block count 64. Partition sizes are undefined until loaded.
`default_nettype none

module fixed_partition_allocator_core
  import fpa_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire in_word_t              in_data,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      out_word_t             out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t             state_r;
  state_t             state_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  out_word_t          out_word_r;
  out_word_t          out_word_nxt;
  out_word_t          pend_r;
  out_word_t          pend_nxt;
  logic [MODE_W-1:0]  fit_mode_r;
  logic [BCNT_W-1:0]  block_count_r;
  logic               in_fire;
  cell_ctl_t          ctl;
  scan_tok_t          tok  [0:MAX_BLOCKS];
  logic [IDX_W-1:0]   bidx [0:MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] tok_vld;
  scan_tok_t          tok_end;
  logic [IDX_W-1:0]   bidx_end;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign tok_end  = tok[MAX_BLOCKS];
  assign bidx_end = bidx[MAX_BLOCKS];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r    <= '0;
      block_count_r <= BLOCK_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_FIT_MODE:    fit_mode_r    <= cfg_wdata[MODE_W-1:0];
        CFG_BLOCK_COUNT: block_count_r <= cfg_wdata[BCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Broadcast controls to the cell row.
  always_comb begin
    ctl.clear       = in_fire && (in_data.op == OP_CLEAR);
    ctl.wr_en       = in_fire && (in_data.op == OP_LOAD);
    ctl.wr_idx      = in_data.block_index;
    ctl.wr_size     = in_data.size;
    ctl.grant_en    = tok_end.valid && tok_end.found;
    ctl.mode        = fit_mode_r;
    ctl.block_count = block_count_r;
  end

  // A request word launches a fresh token into the first cell.
  always_comb begin
    tok[0].valid     = in_fire && (in_data.op == OP_REQ);
    tok[0].found     = 1'b0;
    tok[0].req       = in_data.size;
    tok[0].best_size = '0;
    bidx[0]          = '0;
  end

  // Row of partition cells.
  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    fpa_cell #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .CELL_IDX   (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .grant_idx (bidx_end),
      .tok_in    (tok[g]),
      .bidx_in   (bidx[g]),
      .tok_out   (tok[g+1]),
      .bidx_out  (bidx[g+1])
    );
    assign tok_vld[g] = tok[g+1].valid;
  end

  // Sequencer next state and result staging.
  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data.op == OP_REQ) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt              = S_DONE;
            pend_nxt.status        = ST_DONE;
            pend_nxt.granted_block = '0;
          end
        end
      end
      S_SCAN: begin
        if (tok_end.valid) begin
          state_nxt = S_DONE;
          if (tok_end.found) begin
            pend_nxt.status        = ST_ALLOC;
            pend_nxt.granted_block = BIDX_W'(bidx_end);
          end else begin
            pend_nxt.status        = ST_NONE;
            pend_nxt.granted_block = '0;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = pend_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_word_r <= out_word_nxt;
    pend_r     <= pend_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // Exactly one token walks the row during a search, none otherwise.
  a_one_tok_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> $onehot(tok_vld))
    else $error("search token lost or duplicated");

  a_no_tok_outside_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_SCAN) |-> (tok_vld == '0))
    else $error("token in row outside a search");

  // A launched request is in the first cell on the next cycle.
  a_launch: assert property (@(posedge clk) disable iff (!rst_n)
    tok[0].valid |=> (tok_vld[0] && (state_r == S_SCAN)))
    else $error("request token not launched");

  // A word without a grant reports block zero.
  a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_word_r.status != ST_ALLOC)) |-> (out_word_r.granted_block == '0))
    else $error("nonzero block index without a grant");

endmodule

`default_nettype wire

@@ verif/tb_fixed_partition_allocator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-partition allocator core testbench
// Drives load, clear and allocation request words into the core under all
// fit modes and block counts, predicts each result word from a local copy of
// the partition table and taken flags, and checks every result word in order.
// ----------------------------------------------------------------------------

module tb_fixed_partition_allocator_core;
  import fpa_pkg::*;

  localparam int MAX_BLOCKS = MAX_BLOCKS_DEF;

  // Codes that the package leaves unnamed.
  localparam logic [OP_W-1:0]   OP_UNUSED  = 2'd3;
  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_word_t              in_data;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Local copy of the allocator state and its registers.
  logic [SIZE_W-1:0]     part_size [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] part_taken;
  logic [MODE_W-1:0]     cur_mode;
  logic [BCNT_W-1:0]     cur_count;

  out_word_t pending_results[$];

  int sender_idle_pct;
  int receiver_stall_pct;
  int mismatch_count;
  int words_sent;
  int results_seen;
  int grants_seen;
  int refusals_seen;
  int config_writes;

  fixed_partition_allocator_core #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Works out the result word of one accepted input word and updates the
  // local state the way the core should.
  function automatic out_word_t predict_allocation(input in_word_t w);
    out_word_t         r;
    int unsigned       n;
    bit                hit;
    int unsigned       pick;
    logic [SIZE_W-1:0] pick_size;
    r.status        = ST_DONE;
    r.granted_block = '0;
    case (w.op)
      OP_LOAD: begin
        part_size[w.block_index] = w.size;
      end
      OP_CLEAR: begin
        part_taken = '0;
      end
      OP_REQ: begin
        n = (cur_count > MAX_BLOCKS) ? MAX_BLOCKS : cur_count;
        hit = 1'b0;
        pick = 0;
        pick_size = '0;
        for (int i = 0; i < n; i++) begin
          if (!part_taken[i] && part_size[i] >= w.size) begin
            if (!hit) begin
              hit = 1'b1;
              pick = i;
              pick_size = part_size[i];
            end else if (cur_mode == MODE_BEST && part_size[i] < pick_size) begin
              pick = i;
              pick_size = part_size[i];
            end else if (cur_mode == MODE_WORST && part_size[i] > pick_size) begin
              pick = i;
              pick_size = part_size[i];
            end
          end
        end
        if (hit) begin
          part_taken[pick] = 1'b1;
          r.status = ST_ALLOC;
          r.granted_block = BIDX_W'(pick);
        end else begin
          r.status = ST_NONE;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic void note_failure(input string what, input out_word_t want,
                                       input out_word_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] MISMATCH %s: expected status %0d block %0d, got status %0d block %0d",
               $realtime, what, want.status, want.granted_block, got.status,
               got.granted_block);
    end
  endfunction

  // Result checker: every accepted result word is matched against the oldest
  // prediction.
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_data.status == ST_ALLOC) grants_seen++;
      if (out_data.status == ST_NONE) refusals_seen++;
      if (pending_results.size() == 0) begin
        note_failure("unexpected result word", '0, out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) note_failure("status", want, out_data);
        if (out_data.granted_block !== want.granted_block) begin
          note_failure("granted_block", want, out_data);
        end
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // Sends one word; called and returning at a falling edge.
  task automatic send_word(input in_word_t w);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_allocation(w));
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_op(input logic [OP_W-1:0] op, input int unsigned idx,
                         input int unsigned size);
    in_word_t w;
    w.op          = op;
    w.block_index = BIDX_W'(idx);
    w.size        = SIZE_W'(size);
    send_word(w);
  endtask

  // Holds the sender off until every predicted word has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Writes both registers while the core is idle.
  task automatic set_config(input logic [CFG_DATA_W-1:0] mode_val,
                            input logic [CFG_DATA_W-1:0] count_val);
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_FIT_MODE;
    cfg_wdata <= mode_val;
    @(negedge clk);
    cfg_addr  <= CFG_BLOCK_COUNT;
    cfg_wdata <= count_val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_mode  = mode_val[MODE_W-1:0];
    cur_count = count_val;
    config_writes += 2;
  endtask

  // Fills the whole table under the reset settings, then checks that the
  // default block count reaches the last entry and that first fit applies.
  task automatic test_reset_defaults();
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      if (i == 0) send_op(OP_LOAD, i, 0);
      else if (i == MAX_BLOCKS - 1) send_op(OP_LOAD, i, 16'hFFFF);
      else send_op(OP_LOAD, i, $urandom_range(1, 16'hFFFE));
    end
    send_op(OP_REQ, 0, 0);
    send_op(OP_REQ, 5, 16'hFFFF);
    send_op(OP_REQ, 63, 16'hFFFF);
    send_op(OP_UNUSED, 63, 16'hFFFF);
    send_op(OP_CLEAR, 0, 0);
    send_op(OP_REQ, 0, 16'hFFFF);
  endtask

  // Best fit, worst fit and the spare mode code on a small hand-made table
  // with duplicate sizes, so ties have to go to the lower index.
  task automatic test_fit_modes();
    int unsigned sizes [8] = '{100, 50, 200, 50, 300, 200, 80, 300};
    set_config(CFG_DATA_W'(MODE_BEST), 7'd8);
    for (int i = 0; i < 8; i++) send_op(OP_LOAD, i, sizes[i]);
    send_op(OP_CLEAR, 0, 0);
    send_op(OP_REQ, 0, 60);
    send_op(OP_REQ, 0, 50);
    send_op(OP_REQ, 0, 50);
    send_op(OP_REQ, 0, 50);
    set_config(CFG_DATA_W'(MODE_WORST), 7'd8);
    send_op(OP_CLEAR, 0, 0);
    send_op(OP_REQ, 0, 10);
    send_op(OP_REQ, 0, 10);
    send_op(OP_REQ, 0, 250);
    set_config(CFG_DATA_W'(MODE_SPARE), 7'd8);
    send_op(OP_CLEAR, 0, 0);
    send_op(OP_REQ, 0, 150);
    send_op(OP_REQ, 0, 150);
  endtask

  // Block counts of zero, one and above the table depth, and a mode write
  // with the unused upper bits set.
  task automatic test_count_extremes();
    set_config(CFG_DATA_W'(MODE_FIRST), 7'd0);
    send_op(OP_REQ, 0, 0);
    set_config(CFG_DATA_W'(MODE_FIRST), 7'd127);
    send_op(OP_CLEAR, 0, 0);
    send_op(OP_REQ, 0, 16'hFFFF);
    set_config(CFG_DATA_W'(MODE_BEST), 7'd1);
    send_op(OP_CLEAR, 0, 0);
    send_op(OP_REQ, 0, 0);
    send_op(OP_REQ, 0, 0);
    set_config(7'h7E, 7'd64);
    send_op(OP_CLEAR, 0, 0);
    send_op(OP_REQ, 0, 0);
  endtask

  // A load rewrites the size but keeps the taken flag of that entry.
  task automatic test_load_keeps_taken();
    set_config(CFG_DATA_W'(MODE_FIRST), 7'd2);
    send_op(OP_CLEAR, 0, 0);
    send_op(OP_LOAD, 0, 10);
    send_op(OP_LOAD, 1, 20);
    send_op(OP_REQ, 0, 5);
    send_op(OP_LOAD, 0, 1000);
    send_op(OP_REQ, 0, 5);
    send_op(OP_REQ, 0, 5);
    send_op(OP_CLEAR, 0, 0);
    send_op(OP_REQ, 0, 500);
  endtask

  function automatic in_word_t random_word();
    in_word_t    w;
    int unsigned pick;
    w.block_index = BIDX_W'($urandom_range(0, MAX_BLOCKS - 1));
    w.size = $urandom_range(0, 1) ? SIZE_W'($urandom_range(0, 16'hFFFF))
                                  : SIZE_W'($urandom_range(0, 2000));
    pick = $urandom_range(0, 99);
    if (pick < 62) w.op = OP_REQ;
    else if (pick < 86) w.op = OP_LOAD;
    else if (pick < 97) w.op = OP_CLEAR;
    else w.op = OP_UNUSED;
    return w;
  endfunction

  task automatic random_config();
    logic [CFG_DATA_W-1:0] mode_val;
    logic [CFG_DATA_W-1:0] count_val;
    mode_val = CFG_DATA_W'($urandom_range(0, 3));
    if ($urandom_range(0, 7) == 0) begin
      mode_val[CFG_DATA_W-1:MODE_W] = (CFG_DATA_W - MODE_W)'($urandom);
    end
    case ($urandom_range(0, 9))
      0:       count_val = 7'd0;
      1:       count_val = 7'd1;
      2:       count_val = 7'd64;
      3:       count_val = CFG_DATA_W'($urandom_range(65, 127));
      4, 5:    count_val = CFG_DATA_W'($urandom_range(2, 8));
      default: count_val = CFG_DATA_W'($urandom_range(1, 64));
    endcase
    set_config(mode_val, count_val);
  endtask

  // Random traffic under one idling pattern, with a fresh setting every
  // hundred words; each change waits for the core to go idle.
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int count);
    sender_idle_pct    = send_pct;
    receiver_stall_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) random_config();
      send_word(random_word());
    end
  endtask

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_data            = '0;
    cfg_we             = 1'b0;
    cfg_addr           = '0;
    cfg_wdata          = '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    mismatch_count     = 0;
    words_sent         = 0;
    results_seen       = 0;
    grants_seen        = 0;
    refusals_seen      = 0;
    config_writes      = 0;
    part_taken         = '0;
    cur_mode           = MODE_FIRST;
    cur_count          = BLOCK_COUNT_RST;
    for (int i = 0; i < MAX_BLOCKS; i++) part_size[i] = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_fit_modes();
    test_count_extremes();
    test_load_keeps_taken();
    test_random_traffic(18, 81, 600);
    test_random_traffic(81, 18, 600);
    test_random_traffic(0, 0, 600);

    // Let any stray word surface before the verdict.
    drain();
    repeat (MAX_BLOCKS + 4) @(posedge clk);
    if (pending_results.size() != 0) begin
      note_failure("result word never arrived", pending_results[0], '0);
    end

    $display("Covered %0d words in, %0d results back (%0d grants, %0d refusals),",
             words_sent, results_seen, grants_seen, refusals_seen);
    $display("over all fit modes and block counts with %0d register writes.",
             config_writes);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
